// ===== hdl/nmt_pkg.sv =====
// Shared types, codes and constants of the NAT mapping table.
// Used by every module of the block; depends on nothing.
package nmt_pkg;

  localparam int DEF_ENTRIES       = 64;
  localparam int DEF_FIRST_PORT    = 1024;
  localparam int DEF_LAST_PORT     = 65535;
  localparam int DEF_FIRST_ICMP_ID = 1;
  localparam int DEF_LAST_ICMP_ID  = 65535;

  localparam int ADDR_W  = 32;
  localparam int ID_W    = 16;
  localparam int AGE_W   = 16;
  localparam int STAMP_W = 48;
  localparam int BM_AW   = 12;

  localparam logic [1:0] OP_LOOKUP_EXT = 2'd0;
  localparam logic [1:0] OP_LOOKUP_INT = 2'd1;
  localparam logic [1:0] OP_INSERT     = 2'd2;
  localparam logic [1:0] OP_TICK       = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_MISS  = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_NO_ID = 2'd3;

  localparam logic REG_ICMP_TIMEOUT = 1'b0;
  localparam logic REG_TCP_TIMEOUT  = 1'b1;

  localparam logic [15:0] ICMP_TIMEOUT_RST = 16'd60;
  localparam logic [15:0] TCP_TIMEOUT_RST  = 16'd0;

  typedef struct packed {
    logic [1:0]        op;
    logic              proto;
    logic [ADDR_W-1:0] addr;
    logic [ID_W-1:0]   inner;
    logic [ID_W-1:0]   outer;
  } cmd_t;

  typedef struct packed {
    logic               valid;
    logic               kind;
    logic [ADDR_W-1:0]  addr;
    logic [ID_W-1:0]    inner;
    logic [ID_W-1:0]    outer;
    logic [AGE_W-1:0]   age;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

endpackage

// ===== hdl/nmt_front.sv =====
// Front end of the NAT mapping table: takes command words and queues them.
// Depends on nmt_pkg.
module nmt_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  logic [1:0]                  opcode,
  input  logic                        proto_type,
  input  logic [nmt_pkg::ADDR_W-1:0]  inner_addr,
  input  logic [nmt_pkg::ID_W-1:0]    inner_id,
  input  logic [nmt_pkg::ID_W-1:0]    outer_id,
  input  logic                        pop,
  output logic                        full,
  output logic                        cmd_valid,
  output nmt_pkg::cmd_t               cmd
);

  nmt_pkg::cmd_t q_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  nmt_pkg::cmd_t new_cmd;
  logic          do_pop;

  // Only the fields that the operation uses are kept; the rest read as zero.
  always_comb begin
    new_cmd       = '0;
    new_cmd.op    = opcode;
    new_cmd.proto = proto_type;
    case (opcode)
      nmt_pkg::OP_LOOKUP_EXT: new_cmd.outer = outer_id;
      nmt_pkg::OP_LOOKUP_INT, nmt_pkg::OP_INSERT: begin
        new_cmd.addr  = inner_addr;
        new_cmd.inner = inner_id;
      end
      default: ;
    endcase
  end

  assign full      = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign do_pop    = pop && cmd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

// ===== hdl/nmt_back.sv =====
// Back end of the NAT mapping table: entry memory, id bitmaps and the
// sequencer that carries out lookups, inserts and ticks. Depends on nmt_pkg.
module nmt_back #(
  parameter int ENTRIES       = nmt_pkg::DEF_ENTRIES,
  parameter int FIRST_PORT    = nmt_pkg::DEF_FIRST_PORT,
  parameter int LAST_PORT     = nmt_pkg::DEF_LAST_PORT,
  parameter int FIRST_ICMP_ID = nmt_pkg::DEF_FIRST_ICMP_ID,
  parameter int LAST_ICMP_ID  = nmt_pkg::DEF_LAST_ICMP_ID
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cmd_valid,
  input  nmt_pkg::cmd_t              cmd,
  output logic                       cmd_pop,
  output logic                       clearing,
  input  logic [15:0]                icmp_timeout,
  input  logic [15:0]                tcp_timeout,
  output logic                       res_valid,
  output logic [1:0]                 res_status,
  output logic [nmt_pkg::ADDR_W-1:0] res_addr,
  output logic [nmt_pkg::ID_W-1:0]   res_inner,
  output logic [nmt_pkg::ID_W-1:0]   res_outer,
  output logic [6:0]                 res_removed
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int BM_AW = nmt_pkg::BM_AW;
  localparam int BM_DEPTH = 1 << BM_AW;
  localparam logic [IDX_W:0] ENT_END = (IDX_W + 1)'(ENTRIES);
  localparam logic [BM_AW:0] ENT_CLR = (BM_AW + 1)'(ENTRIES);
  localparam logic [15:0] P_FIRST = 16'(FIRST_PORT);
  localparam logic [15:0] P_LAST  = 16'(LAST_PORT);
  localparam logic [15:0] I_FIRST = 16'(FIRST_ICMP_ID);
  localparam logic [15:0] I_LAST  = 16'(LAST_ICMP_ID);

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_LK     = 4'd2;
  localparam logic [3:0] S_SLOT   = 4'd3;
  localparam logic [3:0] S_AL_RD  = 4'd4;
  localparam logic [3:0] S_AL_EV  = 4'd5;
  localparam logic [3:0] S_TK_RD  = 4'd6;
  localparam logic [3:0] S_TK_EV  = 4'd7;
  localparam logic [3:0] S_TK_BW  = 4'd8;

  nmt_pkg::entry_t ent_mem [ENTRIES];
  nmt_pkg::entry_t ent_rdata_r;
  logic [31:0]     bm_mem [BM_DEPTH];
  logic [31:0]     bm_rdata_r;

  logic [3:0]       state_r, state_nxt;
  logic [IDX_W:0]   idx_r, idx_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  nmt_pkg::cmd_t    cmd_r, cmd_nxt;
  logic [BM_AW-1:0] clr_idx_r, clr_idx_nxt;
  logic [BM_AW-1:0] word_r, word_nxt;
  logic [4:0]       bit_r, bit_nxt;
  logic             best_found_r, best_found_nxt;
  logic [nmt_pkg::STAMP_W-1:0] best_stamp_r, best_stamp_nxt;
  logic [nmt_pkg::ADDR_W-1:0]  best_addr_r, best_addr_nxt;
  logic [nmt_pkg::ID_W-1:0]    best_inner_r, best_inner_nxt;
  logic [nmt_pkg::ID_W-1:0]    best_outer_r, best_outer_nxt;
  logic             slot_found_r, slot_found_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  logic [nmt_pkg::STAMP_W-1:0] seq_r, seq_nxt;
  logic [CNT_W-1:0] rm_cnt_r, rm_cnt_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  logic [nmt_pkg::ADDR_W-1:0] out_addr_r, out_addr_nxt;
  logic [nmt_pkg::ID_W-1:0]   out_inner_r, out_inner_nxt;
  logic [nmt_pkg::ID_W-1:0]   out_outer_r, out_outer_nxt;
  logic [6:0]       out_rm_r, out_rm_nxt;

  logic             ent_we;
  logic [IDX_W-1:0] ent_waddr, ent_raddr;
  nmt_pkg::entry_t  ent_wdata;
  logic             bm_we;
  logic [BM_AW-1:0] bm_waddr, bm_raddr;
  logic [31:0]      bm_wdata;

  nmt_pkg::entry_t  e;
  logic             match;
  logic [15:0]      age_inc, limit;
  logic [15:0]      first_id, last_id;
  logic [4:0]       lo_bit, hi_bit;
  logic [31:0]      range_mask, free_vec;
  logic [4:0]       pos;
  logic [10:0]      rm_ext;
  logic [6:0]       rm_sat;

  assign e        = ent_rdata_r;
  assign first_id = cmd_r.proto ? P_FIRST : I_FIRST;
  assign last_id  = cmd_r.proto ? P_LAST : I_LAST;
  assign age_inc  = (e.age == 16'hFFFF) ? e.age : e.age + 16'd1;
  assign limit    = e.kind ? tcp_timeout : icmp_timeout;
  assign lo_bit   = (word_r[10:0] == first_id[15:5]) ? first_id[4:0] : 5'd0;
  assign hi_bit   = (word_r[10:0] == last_id[15:5]) ? last_id[4:0] : 5'd31;
  assign rm_ext   = 11'(rm_cnt_r);
  assign rm_sat   = (rm_ext > 11'd127) ? 7'd127 : rm_ext[6:0];

  always_comb begin
    match = e.valid && (e.kind == cmd_r.proto);
    if (cmd_r.op == nmt_pkg::OP_LOOKUP_EXT) begin
      match = match && (e.outer == cmd_r.outer);
    end else begin
      match = match && (e.addr == cmd_r.addr) && (e.inner == cmd_r.inner);
    end
  end

  always_comb begin
    for (int b = 0; b < 32; b++) begin
      range_mask[b] = (5'(b) >= lo_bit) && (5'(b) <= hi_bit);
    end
    free_vec = ~bm_rdata_r & range_mask;
    pos = 5'd0;
    for (int b = 31; b >= 0; b--) begin
      if (free_vec[b]) begin
        pos = 5'(b);
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    rd_idx_nxt     = rd_idx_r;
    rd_vld_nxt     = 1'b0;
    cmd_nxt        = cmd_r;
    clr_idx_nxt    = clr_idx_r;
    word_nxt       = word_r;
    bit_nxt        = bit_r;
    best_found_nxt = best_found_r;
    best_stamp_nxt = best_stamp_r;
    best_addr_nxt  = best_addr_r;
    best_inner_nxt = best_inner_r;
    best_outer_nxt = best_outer_r;
    slot_found_nxt = slot_found_r;
    slot_nxt       = slot_r;
    seq_nxt        = seq_r;
    rm_cnt_nxt     = rm_cnt_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    out_inner_nxt  = out_inner_r;
    out_outer_nxt  = out_outer_r;
    out_rm_nxt     = out_rm_r;
    cmd_pop        = 1'b0;
    ent_we         = 1'b0;
    ent_waddr      = rd_idx_r;
    ent_wdata      = e;
    ent_raddr      = idx_r[IDX_W-1:0];
    bm_we          = 1'b0;
    bm_waddr       = word_r;
    bm_wdata       = bm_rdata_r;
    bm_raddr       = word_r;

    case (state_r)
      S_CLR: begin
        ent_we      = ({1'b0, clr_idx_r} < ENT_CLR);
        ent_waddr   = clr_idx_r[IDX_W-1:0];
        ent_wdata   = '0;
        bm_we       = 1'b1;
        bm_waddr    = clr_idx_r;
        bm_wdata    = '0;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == '1) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop        = 1'b1;
          cmd_nxt        = cmd;
          idx_nxt        = '0;
          best_found_nxt = 1'b0;
          best_stamp_nxt = '0;
          best_addr_nxt  = '0;
          best_inner_nxt = '0;
          best_outer_nxt = '0;
          slot_found_nxt = 1'b0;
          rm_cnt_nxt     = '0;
          case (cmd.op)
            nmt_pkg::OP_LOOKUP_EXT, nmt_pkg::OP_LOOKUP_INT: state_nxt = S_LK;
            nmt_pkg::OP_INSERT: state_nxt = S_SLOT;
            default: state_nxt = S_TK_RD;
          endcase
        end
      end

      // Pipelined sweep: one read issued per cycle, the previous word judged.
      S_LK, S_SLOT: begin
        if (idx_r != ENT_END) begin
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = idx_r[IDX_W-1:0];
          idx_nxt    = idx_r + 1'b1;
        end
        if (rd_vld_r) begin
          if (state_r == S_LK) begin
            if (match && (!best_found_r || e.stamp > best_stamp_r)) begin
              best_found_nxt = 1'b1;
              best_stamp_nxt = e.stamp;
              best_addr_nxt  = e.addr;
              best_inner_nxt = e.inner;
              best_outer_nxt = e.outer;
            end
          end else if (!e.valid && !slot_found_r) begin
            slot_found_nxt = 1'b1;
            slot_nxt       = rd_idx_r;
          end
        end
        if (idx_r == ENT_END && !rd_vld_r) begin
          if (state_r == S_LK) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = best_found_r ? nmt_pkg::ST_OK : nmt_pkg::ST_MISS;
            out_addr_nxt   = best_addr_r;
            out_inner_nxt  = best_inner_r;
            out_outer_nxt  = best_outer_r;
            out_rm_nxt     = rm_sat;
            state_nxt      = S_IDLE;
          end else if (!slot_found_r || first_id > last_id) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = slot_found_r ? nmt_pkg::ST_NO_ID : nmt_pkg::ST_FULL;
            out_addr_nxt   = '0;
            out_inner_nxt  = '0;
            out_outer_nxt  = '0;
            out_rm_nxt     = rm_sat;
            state_nxt      = S_IDLE;
          end else begin
            word_nxt  = {cmd_r.proto, first_id[15:5]};
            state_nxt = S_AL_RD;
          end
        end
      end

      S_AL_RD: begin
        state_nxt = S_AL_EV;
      end

      S_AL_EV: begin
        if (free_vec != '0) begin
          bm_we           = 1'b1;
          bm_wdata        = bm_rdata_r | (32'd1 << pos);
          ent_we          = 1'b1;
          ent_waddr       = slot_r;
          ent_wdata.valid = 1'b1;
          ent_wdata.kind  = cmd_r.proto;
          ent_wdata.addr  = cmd_r.addr;
          ent_wdata.inner = cmd_r.inner;
          ent_wdata.outer = {word_r[10:0], pos};
          ent_wdata.age   = '0;
          ent_wdata.stamp = seq_r;
          seq_nxt         = seq_r + 1'b1;
          out_valid_nxt   = 1'b1;
          out_status_nxt  = nmt_pkg::ST_OK;
          out_addr_nxt    = cmd_r.addr;
          out_inner_nxt   = cmd_r.inner;
          out_outer_nxt   = {word_r[10:0], pos};
          out_rm_nxt      = rm_sat;
          state_nxt       = S_IDLE;
        end else if (word_r[10:0] == last_id[15:5]) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = nmt_pkg::ST_NO_ID;
          out_addr_nxt   = '0;
          out_inner_nxt  = '0;
          out_outer_nxt  = '0;
          out_rm_nxt     = rm_sat;
          state_nxt      = S_IDLE;
        end else begin
          word_nxt  = word_r + 1'b1;
          state_nxt = S_AL_RD;
        end
      end

      S_TK_RD: begin
        if (idx_r == ENT_END) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = nmt_pkg::ST_OK;
          out_addr_nxt   = '0;
          out_inner_nxt  = '0;
          out_outer_nxt  = '0;
          out_rm_nxt     = rm_sat;
          state_nxt      = S_IDLE;
        end else begin
          rd_idx_nxt = idx_r[IDX_W-1:0];
          state_nxt  = S_TK_EV;
        end
      end

      S_TK_EV: begin
        idx_nxt   = idx_r + 1'b1;
        state_nxt = S_TK_RD;
        if (e.valid) begin
          ent_we        = 1'b1;
          ent_wdata.age = age_inc;
          if (age_inc > limit) begin
            ent_wdata.valid = 1'b0;
            rm_cnt_nxt      = rm_cnt_r + 1'b1;
            bm_raddr        = {e.kind, e.outer[15:5]};
            word_nxt        = {e.kind, e.outer[15:5]};
            bit_nxt         = e.outer[4:0];
            idx_nxt         = idx_r;
            state_nxt       = S_TK_BW;
          end
        end
      end

      S_TK_BW: begin
        bm_we     = 1'b1;
        bm_wdata  = bm_rdata_r & ~(32'd1 << bit_r);
        idx_nxt   = idx_r + 1'b1;
        state_nxt = S_TK_RD;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_idx_r   <= '0;
      rd_vld_r    <= 1'b0;
      seq_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      rd_vld_r    <= rd_vld_nxt;
      seq_r       <= seq_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    rd_idx_r     <= rd_idx_nxt;
    cmd_r        <= cmd_nxt;
    word_r       <= word_nxt;
    bit_r        <= bit_nxt;
    best_found_r <= best_found_nxt;
    best_stamp_r <= best_stamp_nxt;
    best_addr_r  <= best_addr_nxt;
    best_inner_r <= best_inner_nxt;
    best_outer_r <= best_outer_nxt;
    slot_found_r <= slot_found_nxt;
    slot_r       <= slot_nxt;
    rm_cnt_r     <= rm_cnt_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_inner_r  <= out_inner_nxt;
    out_outer_r  <= out_outer_nxt;
    out_rm_r     <= out_rm_nxt;
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    ent_rdata_r <= ent_mem[ent_raddr];
  end

  always_ff @(posedge clk) begin
    if (bm_we) begin
      bm_mem[bm_waddr] <= bm_wdata;
    end
    bm_rdata_r <= bm_mem[bm_raddr];
  end

  assign clearing    = (state_r == S_CLR);
  assign res_valid   = out_valid_r;
  assign res_status  = out_status_r;
  assign res_addr    = out_addr_r;
  assign res_inner   = out_inner_r;
  assign res_outer   = out_outer_r;
  assign res_removed = out_rm_r;

endmodule

// ===== hdl/nat_mapping_table_top.sv =====
// Top level of the NAT mapping table: configuration registers, command
// front end and execution back end. Depends on nmt_pkg, nmt_front, nmt_back.
//
// The table holds up to ENTRIES mappings from an internal address and id to
// an external id. Each command word (lookup by external id, lookup by internal
// address and id, insert, tick) is taken when start is high and busy is low,
// and produces exactly one result word, shown for a single cycle with
// out_valid high; the receiver cannot stall, so it must take every result.
// Two commands can wait in the queue in front of the execution engine while
// it works. After reset the engine first clears its entry memory and the two
// id bitmaps in one pass, with busy held high; configuration writes are
// taken during that pass. A lookup sweeps the entry memory, which has a
// single read port, once per command. An insert makes the same sweep and
// then scans the 32-bit bitmap words one by one until a free id turns up.
// A tick reads and then updates each entry in turn, with an extra step for
// each entry it removes, since freeing an id is a read-modify-write of the
// bitmap memory. Newest-match order comes from a 48-bit insertion stamp
// kept with each entry.
module nat_mapping_table_top #(
  parameter int ENTRIES       = nmt_pkg::DEF_ENTRIES,
  parameter int FIRST_PORT    = nmt_pkg::DEF_FIRST_PORT,
  parameter int LAST_PORT     = nmt_pkg::DEF_LAST_PORT,
  parameter int FIRST_ICMP_ID = nmt_pkg::DEF_FIRST_ICMP_ID,
  parameter int LAST_ICMP_ID  = nmt_pkg::DEF_LAST_ICMP_ID
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic        in_proto_type,
  input  logic [31:0] in_inner_addr,
  input  logic [15:0] in_inner_id,
  input  logic [15:0] in_outer_id,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [31:0] out_found_addr,
  output logic [15:0] out_found_inner,
  output logic [15:0] out_found_outer,
  output logic [6:0]  out_removed_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0]   icmp_timeout_r, icmp_timeout_nxt;
  logic [15:0]   tcp_timeout_r, tcp_timeout_nxt;
  logic          cfg_wr;
  logic          q_full;
  logic          q_valid;
  logic          q_pop;
  logic          clearing;
  logic          push;
  nmt_pkg::cmd_t q_cmd;

  // Registers sit on word boundaries; the low two address bits are ignored.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    icmp_timeout_nxt = icmp_timeout_r;
    tcp_timeout_nxt  = tcp_timeout_r;
    if (cfg_wr) begin
      case (paddr[2])
        nmt_pkg::REG_ICMP_TIMEOUT: icmp_timeout_nxt = pwdata[15:0];
        nmt_pkg::REG_TCP_TIMEOUT:  tcp_timeout_nxt  = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      nmt_pkg::REG_ICMP_TIMEOUT: prdata = {16'd0, icmp_timeout_r};
      nmt_pkg::REG_TCP_TIMEOUT:  prdata = {16'd0, tcp_timeout_r};
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      icmp_timeout_r <= nmt_pkg::ICMP_TIMEOUT_RST;
      tcp_timeout_r  <= nmt_pkg::TCP_TIMEOUT_RST;
    end else begin
      icmp_timeout_r <= icmp_timeout_nxt;
      tcp_timeout_r  <= tcp_timeout_nxt;
    end
  end

  // Commands are refused while the queue is full or the memories are
  // still being cleared after reset.
  assign busy = q_full || clearing;
  assign push = start && !busy;

  nmt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .opcode     (in_opcode),
    .proto_type (in_proto_type),
    .inner_addr (in_inner_addr),
    .inner_id   (in_inner_id),
    .outer_id   (in_outer_id),
    .pop        (q_pop),
    .full       (q_full),
    .cmd_valid  (q_valid),
    .cmd        (q_cmd)
  );

  nmt_back #(
    .ENTRIES       (ENTRIES),
    .FIRST_PORT    (FIRST_PORT),
    .LAST_PORT     (LAST_PORT),
    .FIRST_ICMP_ID (FIRST_ICMP_ID),
    .LAST_ICMP_ID  (LAST_ICMP_ID)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (q_valid),
    .cmd          (q_cmd),
    .cmd_pop      (q_pop),
    .clearing     (clearing),
    .icmp_timeout (icmp_timeout_r),
    .tcp_timeout  (tcp_timeout_r),
    .res_valid    (out_valid),
    .res_status   (out_status),
    .res_addr     (out_found_addr),
    .res_inner    (out_found_inner),
    .res_outer    (out_found_outer),
    .res_removed  (out_removed_count)
  );

endmodule

// ===== hdl/nmt_checker.sv =====
// Port-level checks for the NAT mapping table, bound to the top level.
// Depends on nmt_pkg and nat_mapping_table_top.
module nmt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        busy,
  input logic        out_valid,
  input logic [1:0]  out_status,
  input logic [31:0] out_found_addr,
  input logic [15:0] out_found_inner,
  input logic [15:0] out_found_outer,
  input logic [6:0]  out_removed_count
);

  // The memory clearing pass follows every reset.
  a_busy_after_reset: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low right after reset");

  // A command is taken in the idle state and ends in a working state, so result words never abut.
  a_result_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two result words in consecutive cycles");

  // Only a successful tick reports removed entries.
  a_removed_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_removed_count != 7'd0 |-> out_status == nmt_pkg::ST_OK)
    else $error("removed count on a failed command");

  // Failed commands carry no mapping.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != nmt_pkg::ST_OK |->
      out_found_addr == 32'd0 && out_found_inner == 16'd0 &&
      out_found_outer == 16'd0 && out_removed_count == 7'd0)
    else $error("nonzero fields on a failed command");

endmodule

bind nat_mapping_table_top nmt_checker u_nmt_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_status        (out_status),
  .out_found_addr    (out_found_addr),
  .out_found_inner   (out_found_inner),
  .out_found_outer   (out_found_outer),
  .out_removed_count (out_removed_count)
);
